/* design/scdec_pkg.sv */
`default_nettype none

package scdec_pkg;

	// default entries per layout table
	localparam int unsigned TABLE_DEPTH_DEF = 128;

	// scan codes of interest
	localparam logic [7:0] PREFIX_BYTE = 8'hE0;
	localparam logic [7:0] KEY_LSHIFT  = 8'h2A;
	localparam logic [7:0] KEY_RSHIFT  = 8'h36;
	localparam logic [7:0] KEY_CTRL    = 8'h1D;
	localparam logic [7:0] KEY_ALT     = 8'h38;
	localparam logic [7:0] KEY_CAPS    = 8'h3A;
	localparam logic [7:0] RELEASE_BIT = 8'h80;

	// modifier flag positions
	localparam int unsigned MOD_LSHIFT = 0;
	localparam int unsigned MOD_RSHIFT = 1;
	localparam int unsigned MOD_LCTRL  = 2;
	localparam int unsigned MOD_RCTRL  = 3;
	localparam int unsigned MOD_LALT   = 4;
	localparam int unsigned MOD_RALT   = 5;
	localparam int unsigned MOD_CAPS   = 6;
	localparam int unsigned MOD_W      = 7;

	// request kind carried in tuser
	typedef enum logic {
		CMD_SCAN  = 1'b0,
		CMD_WRITE = 1'b1
	} cmd_t;

	// layout table selector
	typedef enum logic [1:0] {
		TBL_NORMAL = 2'd0,
		TBL_SHIFT  = 2'd1,
		TBL_ALTGR  = 2'd2,
		TBL_NONE   = 2'd3
	} tbl_sel_t;

	// memory access issued by the front end
	typedef struct packed {
		logic rd;    // table lookup for a key press
		logic wr;    // table entry load
		logic caps;  // fold a..z to upper case on the looked-up byte
	} mem_req_t;

endpackage

`default_nettype wire

/* design/scancode_to_ascii_decoder_top.sv */
`default_nettype none

// Channel  Dir  tdata                                              tuser
// s_       in   [7:0] scan_byte [9:8] table_select [16:10] idx      cmd
//               [24:17] table_char, [31:25] zero
// m_       out  [7:0] ascii_char                                    -
//
// One request per cycle unless stalled; presses pass the RAM read and output register.
// Throughput is set by the single memory port: one lookup or one table load a cycle.
// Reset clears the modifier flags, the prefix and the pipeline; table contents persist.
// A held result blocks the lookup stage, and input is held off only while that stage is full.

module scancode_to_ascii_decoder_top
	import scdec_pkg::*;
#(
	parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // scan_byte, table_select, table_index, table_char
	input  wire logic        s_tuser,   // cmd
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata    // ascii_char
);

	localparam int unsigned MemDepth = 3 * TABLE_DEPTH;
	localparam int unsigned AddrW    = $clog2(MemDepth);

	mem_req_t         req;
	logic [AddrW-1:0] addr;
	logic [7:0]       rdata;
	logic             accept;

	assign accept = s_tvalid && s_tready;

	// flags, prefix and address generation
	scdec_front #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.cmd         (cmd_t'(s_tuser)),
		.scan_byte   (s_tdata[7:0]),
		.table_select(tbl_sel_t'(s_tdata[9:8])),
		.table_index (s_tdata[16:10]),
		.req         (req),
		.addr        (addr)
	);

	// layout tables, three banks of TABLE_DEPTH bytes
	scdec_ram #(
		.WIDTH(8),
		.DEPTH(MemDepth)
	) u_ram (
		.clk  (clk),
		.en   (req.rd || req.wr),
		.we   (req.wr),
		.addr (addr),
		.wdata(s_tdata[24:17]),
		.rdata(rdata)
	);

	// case fold and output register
	scdec_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.lookup   (req.rd),
		.caps     (req.caps),
		.rdata    (rdata),
		.s1_free  (s_tready),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_char (m_tdata)
	);

endmodule

`default_nettype wire

/* design/scdec_ram.sv */
`default_nettype none

module scdec_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 384
) (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// single port, registered read; read data holds when idle or writing
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata <= mem_q[addr];
			end
		end
	end

endmodule

`default_nettype wire

/* design/scdec_front.sv */
`default_nettype none

module scdec_front
	import scdec_pkg::*;
#(
	parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
	localparam int unsigned AddrW = $clog2(3 * TABLE_DEPTH)
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           accept,
	input  wire cmd_t           cmd,
	input  wire logic [7:0]     scan_byte,
	input  wire tbl_sel_t       table_select,
	input  wire logic [6:0]     table_index,
	output mem_req_t            req,
	output logic [AddrW-1:0]    addr
);

	logic [MOD_W-1:0] flags_q;
	logic             ext_q;
	logic [MOD_W-1:0] flags_nxt;
	logic             is_scan;
	logic             is_prefix;
	logic             is_mod;
	logic             ctl_bit_r;
	tbl_sel_t         rd_tbl;

	assign is_scan   = accept && (cmd == CMD_SCAN);
	assign is_prefix = !ext_q && (scan_byte == PREFIX_BYTE);
	assign ctl_bit_r = ext_q;

	// modifier decode; prefix selects the right-hand ctrl and alt flags
	always_comb begin
		flags_nxt = flags_q;
		is_mod    = 1'b1;
		unique case (scan_byte)
			KEY_LSHIFT:                flags_nxt[MOD_LSHIFT] = 1'b1;
			KEY_LSHIFT | RELEASE_BIT:  flags_nxt[MOD_LSHIFT] = 1'b0;
			KEY_RSHIFT:                flags_nxt[MOD_RSHIFT] = 1'b1;
			KEY_RSHIFT | RELEASE_BIT:  flags_nxt[MOD_RSHIFT] = 1'b0;
			KEY_CTRL: begin
				if (ctl_bit_r) flags_nxt[MOD_RCTRL] = 1'b1;
				else           flags_nxt[MOD_LCTRL] = 1'b1;
			end
			KEY_CTRL | RELEASE_BIT: begin
				if (ctl_bit_r) flags_nxt[MOD_RCTRL] = 1'b0;
				else           flags_nxt[MOD_LCTRL] = 1'b0;
			end
			KEY_ALT: begin
				if (ctl_bit_r) flags_nxt[MOD_RALT] = 1'b1;
				else           flags_nxt[MOD_LALT] = 1'b1;
			end
			KEY_ALT | RELEASE_BIT: begin
				if (ctl_bit_r) flags_nxt[MOD_RALT] = 1'b0;
				else           flags_nxt[MOD_LALT] = 1'b0;
			end
			KEY_CAPS:                  flags_nxt[MOD_CAPS] = !flags_q[MOD_CAPS];
			default:                   is_mod = 1'b0;
		endcase
	end

	// table choice: shift first, then both alts, else normal
	always_comb begin
		priority if (flags_q[MOD_LSHIFT] || flags_q[MOD_RSHIFT]) begin
			rd_tbl = TBL_SHIFT;
		end else if (flags_q[MOD_LALT] && flags_q[MOD_RALT]) begin
			rd_tbl = TBL_ALTGR;
		end else begin
			rd_tbl = TBL_NORMAL;
		end
	end

	// memory request and address
	always_comb begin
		req.rd   = is_scan && !is_prefix && !is_mod && !scan_byte[7];
		req.wr   = accept && (cmd == CMD_WRITE) && (table_select != TBL_NONE);
		req.caps = flags_q[MOD_CAPS] && (rd_tbl == TBL_NORMAL);
		if (cmd == CMD_WRITE) begin
			addr = AddrW'(table_select) * AddrW'(TABLE_DEPTH) + AddrW'(table_index);
		end else begin
			addr = AddrW'(rd_tbl) * AddrW'(TABLE_DEPTH) + AddrW'(scan_byte[6:0]);
		end
	end

	// flag and prefix registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
			ext_q   <= 1'b0;
		end else if (is_scan) begin
			ext_q <= is_prefix;
			if (!is_prefix) begin
				flags_q <= flags_nxt;
			end
		end
	end

	// a fresh prefix is remembered for the next byte
	a_prefix_held: assert property (@(posedge clk) disable iff (!arst_n)
		(is_scan && is_prefix) |=> ext_q)
		else $error("prefix not held");

	// caps lock press toggles the caps flag
	a_caps_toggle: assert property (@(posedge clk) disable iff (!arst_n)
		(is_scan && !is_prefix && scan_byte == KEY_CAPS)
		|=> (flags_q[MOD_CAPS] != $past(flags_q[MOD_CAPS])))
		else $error("caps lock did not toggle");

endmodule

`default_nettype wire

/* design/scdec_emit.sv */
`default_nettype none

module scdec_emit
	import scdec_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       lookup,
	input  wire logic       caps,
	input  wire logic [7:0] rdata,
	output logic            s1_free,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_char
);

	logic       s1_valid_s1;
	logic       caps_s1;
	logic       out_valid_q;
	logic [7:0] out_char_q;
	logic [7:0] chr;
	logic       out_free;

	// caps lock folds lower case letters only
	always_comb begin
		chr = rdata;
		if (caps_s1 && rdata >= 8'h61 && rdata <= 8'h7A) begin
			chr = {rdata[7:6], 1'b0, rdata[4:0]};
		end
	end

	assign out_free  = !out_valid_q || out_ready;
	assign s1_free   = !s1_valid_s1 || (chr == 8'h00) || out_free;
	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;

	// lookup stage, waiting on the memory read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
			caps_s1     <= 1'b0;
		end else if (s1_free) begin
			s1_valid_s1 <= lookup;
			caps_s1     <= caps;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= s1_valid_s1 && (chr != 8'h00);
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_char_q <= chr;
		end
	end

	// a result is never a zero byte
	a_no_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_char_q != 8'h00))
		else $error("zero character emitted");

	// no new lookup while the stage is blocked
	a_stall_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_s1 && !s1_free) |-> !lookup)
		else $error("lookup issued into a blocked stage");

endmodule

`default_nettype wire

/* verif/tb.sv */
`timescale 1ns / 100ps

module tb;
	import scdec_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int unsigned ITEM_TARGET  = 1150;
	localparam int unsigned QUIET_FROM   = 1050;
	localparam int unsigned HOLD_AT      = 700;
	localparam int unsigned DRAIN_CYCLES = 8;

	// a key whose entries the directed part sets up
	localparam logic [7:0] KEY_A        = 8'h1E;
	localparam logic [7:0] CHR_LOWER_A  = "a";
	localparam logic [7:0] CHR_LOWER_Z  = "z";
	localparam logic [7:0] CASE_OFFSET  = 8'h20;

	// predicts the decoded characters and checks them in order
	class keymap_scoreboard;
		logic [MOD_W-1:0] mods;
		bit               prefix_held;
		logic [7:0]       layout [3][TABLE_DEPTH_DEF];
		logic [7:0]       expected_chars [$];
		int unsigned      mismatches;

		function new();
			mods        = '0;
			prefix_held = 1'b0;
			mismatches  = 0;
		endfunction

		task report(string msg);
			$display("ERROR: %s", msg);
			mismatches++;
		endtask

		function void note_request(cmd_t kind, logic [31:0] data);
			logic [7:0]  scan;
			tbl_sel_t    sel;
			logic [6:0]  idx;
			logic [7:0]  ch;
			bit          ext;
			bit          is_mod;
			logic [2:0]  ctl_bit;
			logic [2:0]  alt_bit;
			scan = data[7:0];
			sel  = tbl_sel_t'(data[9:8]);
			idx  = data[16:10];
			ch   = data[24:17];

			// table load; selector three is dropped
			if (kind == CMD_WRITE) begin
				if (sel != TBL_NONE)
					layout[sel][idx] = ch;
				return;
			end

			if (!prefix_held && scan == PREFIX_BYTE) begin
				prefix_held = 1'b1;
				return;
			end
			ext         = prefix_held;
			prefix_held = 1'b0;

			// modifier bytes, prefix picks the right-hand ctrl/alt
			ctl_bit = ext ? 3'(MOD_RCTRL) : 3'(MOD_LCTRL);
			alt_bit = ext ? 3'(MOD_RALT) : 3'(MOD_LALT);
			is_mod  = 1'b1;
			case (scan)
				KEY_LSHIFT:               mods[MOD_LSHIFT] = 1'b1;
				KEY_LSHIFT | RELEASE_BIT: mods[MOD_LSHIFT] = 1'b0;
				KEY_RSHIFT:               mods[MOD_RSHIFT] = 1'b1;
				KEY_RSHIFT | RELEASE_BIT: mods[MOD_RSHIFT] = 1'b0;
				KEY_CTRL:                 mods[ctl_bit] = 1'b1;
				KEY_CTRL | RELEASE_BIT:   mods[ctl_bit] = 1'b0;
				KEY_ALT:                  mods[alt_bit] = 1'b1;
				KEY_ALT | RELEASE_BIT:    mods[alt_bit] = 1'b0;
				KEY_CAPS:                 mods[MOD_CAPS] = ~mods[MOD_CAPS];
				default:                  is_mod = 1'b0;
			endcase
			if (is_mod || scan[7])
				return;

			// table choice: shift first, then altgr, else normal with caps fold
			if (mods[MOD_LSHIFT] || mods[MOD_RSHIFT]) begin
				ch = layout[TBL_SHIFT][scan[6:0]];
			end else if (mods[MOD_LALT] && mods[MOD_RALT]) begin
				ch = layout[TBL_ALTGR][scan[6:0]];
			end else begin
				ch = layout[TBL_NORMAL][scan[6:0]];
				if (mods[MOD_CAPS] && ch >= CHR_LOWER_A && ch <= CHR_LOWER_Z)
					ch = ch - CASE_OFFSET;
			end
			if (ch != 8'h00)
				expected_chars.push_back(ch);
		endfunction

		task check_char(logic [7:0] got);
			logic [7:0] want;
			if (expected_chars.size() == 0) begin
				report($sformatf("character %02h with none expected", got));
				return;
			end
			want = expected_chars.pop_front();
			if (got !== want)
				report($sformatf("ascii_char got %02h, want %02h", got, want));
		endtask
	endclass

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = '0;
	logic        s_tuser  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;

	keymap_scoreboard sb;
	bit          quiet = 1'b0;
	bit          held_once = 1'b0;
	int unsigned items_sent = 0;
	int unsigned cycles = 0;
	int unsigned ready_stall = 0;

	scancode_to_ascii_decoder_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// result side: random stall bursts, none in the quiet tail
	always @(negedge clk) begin
		if (quiet) begin
			m_tready <= 1'b1;
		end else if (ready_stall != 0) begin
			m_tready <= 1'b0;
			ready_stall--;
		end else if ($urandom_range(0, 9) == 0) begin
			m_tready <= 1'b0;
			ready_stall = $urandom_range(0, 11);
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid === 1'b1 && m_tready)
			sb.check_char(m_tdata);
	end

	function automatic logic [7:0] random_char();
		case ($urandom_range(0, 9))
			0, 1:       return 8'h00;
			2, 3, 4, 5: return CHR_LOWER_A + 8'($urandom_range(0, 25));
			default:    return 8'($urandom_range(1, 255));
		endcase
	endfunction

	// entered and left at a falling edge
	task automatic pause_sender(int unsigned n);
		s_tvalid <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	task automatic send_request(cmd_t kind, logic [31:0] data);
		if (!quiet && $urandom_range(0, 7) == 0)
			pause_sender($urandom_range(1, 12));
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= data;
		do @(posedge clk); while (s_tready !== 1'b1);
		sb.note_request(kind, data);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_scan(logic [7:0] b);
		logic [31:0] data;
		data        = $urandom;
		data[31:25] = '0;
		data[7:0]   = b;
		send_request(CMD_SCAN, data);
	endtask

	task automatic send_write(tbl_sel_t sel, logic [6:0] idx, logic [7:0] ch);
		send_request(CMD_WRITE, {7'd0, ch, idx, sel, 8'($urandom)});
	endtask

	task automatic tap_key(bit ext, logic [7:0] k);
		if (ext)
			send_scan(PREFIX_BYTE);
		send_scan(k);
		if (ext)
			send_scan(PREFIX_BYTE);
		send_scan(k | RELEASE_BIT);
	endtask

	task automatic tap_some_keys();
		repeat ($urandom_range(1, 4))
			tap_key($urandom_range(0, 3) == 0, 8'($urandom_range(0, 127)));
	endtask

	// hold the sender until every character is out and the pipe is empty
	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		while (sb.expected_chars.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	initial begin
		logic [7:0] mod_key;
		bit         ext;
		sb = new();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// fill every entry so no press reads an unloaded one
		for (int sel = 0; sel < 3; sel++)
			for (int idx = 0; idx < TABLE_DEPTH_DEF; idx++)
				send_write(tbl_sel_t'(sel), 7'(idx), random_char());

		// directed: one key in every table, zero entry, dropped selector
		send_write(TBL_NORMAL, KEY_A[6:0], CHR_LOWER_A);
		send_write(TBL_SHIFT, KEY_A[6:0], 8'hFF);
		send_write(TBL_ALTGR, KEY_A[6:0], 8'h40);
		send_write(TBL_NONE, KEY_A[6:0], 8'h55);
		send_write(TBL_NORMAL, 7'h00, 8'h00);
		send_write(TBL_NORMAL, 7'h7F, 8'hFF);

		send_scan(KEY_A);
		send_scan(KEY_CAPS);
		send_scan(KEY_A);
		send_scan(KEY_CAPS | RELEASE_BIT);
		send_scan(KEY_LSHIFT);
		send_scan(KEY_A);
		send_scan(KEY_LSHIFT | RELEASE_BIT);
		// prefixed right shift
		send_scan(PREFIX_BYTE);
		send_scan(KEY_RSHIFT);
		send_scan(KEY_A);
		send_scan(KEY_RSHIFT | RELEASE_BIT);
		// both alts for altgr
		send_scan(KEY_ALT);
		send_scan(PREFIX_BYTE);
		send_scan(KEY_ALT);
		send_scan(KEY_A);
		send_scan(PREFIX_BYTE);
		send_scan(KEY_ALT | RELEASE_BIT);
		send_scan(KEY_ALT | RELEASE_BIT);
		// right ctrl, prefix after prefix, extended press
		send_scan(PREFIX_BYTE);
		send_scan(KEY_CTRL);
		send_scan(PREFIX_BYTE);
		send_scan(PREFIX_BYTE);
		send_scan(PREFIX_BYTE);
		send_scan(KEY_A);
		send_scan(8'h00);
		send_scan(8'h7F);
		send_scan(8'hFF);
		send_scan(PREFIX_BYTE);
		send_scan(KEY_CTRL | RELEASE_BIT);
		wait_for_results();

		// random: mostly key sequences with random content, some noise
		while (items_sent < ITEM_TARGET) begin
			if (items_sent >= QUIET_FROM)
				quiet = 1'b1;
			if (!held_once && items_sent >= HOLD_AT) begin
				wait_for_results();
				held_once = 1'b1;
			end
			case ($urandom_range(0, 11))
				0, 1, 2, 3: begin
					tap_key($urandom_range(0, 3) == 0, 8'($urandom_range(0, 127)));
				end
				4: begin
					mod_key = $urandom_range(0, 1) ? KEY_LSHIFT : KEY_RSHIFT;
					ext     = $urandom_range(0, 2) == 0;
					if (ext)
						send_scan(PREFIX_BYTE);
					send_scan(mod_key);
					tap_some_keys();
					send_scan(mod_key | RELEASE_BIT);
				end
				5, 6: begin
					send_scan(KEY_ALT);
					send_scan(PREFIX_BYTE);
					send_scan(KEY_ALT);
					tap_some_keys();
					send_scan(PREFIX_BYTE);
					send_scan(KEY_ALT | RELEASE_BIT);
					send_scan(KEY_ALT | RELEASE_BIT);
				end
				7: begin
					ext = ($urandom_range(0, 1) == 1);
					if (ext)
						send_scan(PREFIX_BYTE);
					send_scan(KEY_CTRL);
					tap_some_keys();
					if (ext)
						send_scan(PREFIX_BYTE);
					send_scan(KEY_CTRL | RELEASE_BIT);
				end
				8: begin
					send_scan(KEY_CAPS);
					send_scan(KEY_CAPS | RELEASE_BIT);
				end
				9: begin
					send_write(tbl_sel_t'($urandom_range(0, 3)),
						7'($urandom_range(0, 127)), random_char());
				end
				default: begin
					repeat ($urandom_range(1, 3))
						send_scan($urandom_range(0, 3) == 0 ? PREFIX_BYTE
							: 8'($urandom_range(0, 255)));
				end
			endcase
		end

		s_tvalid <= 1'b0;
		while (sb.expected_chars.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
